>>> sv/evd_pkg.sv
// Shared types and constants for the Euclidean vector distance block.
package evd_pkg;

	localparam int ELEM_W    = 16;
	localparam int MAG_W     = 16;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int SUM_W     = 46;
	localparam int ROOT_W    = 23;
	localparam int REM_W     = ROOT_W + 1;
	localparam int CNT_W     = $clog2(ROOT_W);
	localparam int S_TDATA_W = 2 * ELEM_W;
	localparam int M_TDATA_W = ((ROOT_W + 7) / 8) * 8;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic             sat;
		logic [SUM_W-1:0] sum;
	} evd_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} evd_q_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_DONE
	} evd_state_t;

endpackage

>>> sv/evd_front.sv
// Front end: takes element pairs and accumulates saturating squared differences.
module evd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [evd_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tlast,
	input  evd_pkg::evd_q_stat_t          q_stat,
	output logic                          push,
	output evd_pkg::evd_entry_t           entry
);
	import evd_pkg::*;

	logic signed [ELEM_W:0] diff;
	logic [ELEM_W:0]        diff_abs;
	logic                   stall;
	logic                   en;
	logic                   v_s1, v_s2;
	logic                   last_s1, last_s2;
	logic [MAG_W-1:0]       mag_s1;
	logic [SQ_W-1:0]        sq_s2;
	logic [SUM_W-1:0]       sum_q;
	logic                   sat_q;
	logic [SUM_W:0]         acc_wide;
	logic [SUM_W-1:0]       acc_sum;
	logic                   acc_sat;

	always_comb begin
		diff = $signed({s_tdata[ELEM_W-1], s_tdata[ELEM_W-1:0]})
			- $signed({s_tdata[S_TDATA_W-1], s_tdata[S_TDATA_W-1:ELEM_W]});
		diff_abs = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;
	end

	assign stall    = v_s2 & last_s2 & q_stat.full;
	assign en       = ~stall;
	assign s_tready = en;

	always_comb begin
		acc_wide = {1'b0, sum_q} + (SUM_W+1)'(sq_s2);
		acc_sat  = acc_wide[SUM_W];
		acc_sum  = acc_sat ? {SUM_W{1'b1}} : acc_wide[SUM_W-1:0];
	end

	assign push      = v_s2 & last_s2 & ~q_stat.full;
	assign entry.sum = acc_sum;
	assign entry.sat = sat_q | acc_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			sum_q <= '0;
			sat_q <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			if (v_s2) begin
				if (last_s2) begin
					sum_q <= '0;
					sat_q <= 1'b0;
				end else begin
					sum_q <= acc_sum;
					sat_q <= sat_q | acc_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= s_tlast;
			mag_s1  <= diff_abs[MAG_W-1:0];
			last_s2 <= last_s1;
			sq_s2   <= mag_s1 * mag_s1;
		end
	end

endmodule

>>> sv/evd_queue.sv
// Short queue of finished sums between the accumulator and the root unit.
module evd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  evd_pkg::evd_entry_t  wr_data,
	input  logic                 pop,
	output evd_pkg::evd_entry_t  rd_data,
	output evd_pkg::evd_q_stat_t stat
);
	import evd_pkg::*;

	evd_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign stat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> sv/evd_root.sv
// Back end: bit-serial integer square root and the result output register.
module evd_root (
	input  logic                          clk,
	input  logic                          arst_n,
	input  evd_pkg::evd_q_stat_t          q_stat,
	input  evd_pkg::evd_entry_t           rd_data,
	output logic                          pop,
	output logic                          done,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [evd_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tuser
);
	import evd_pkg::*;

	evd_state_t        state_q, state_d;
	logic [SUM_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic              sat_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovalid_q;
	logic [ROOT_W-1:0] dist_q;
	logic              ovf_q;
	logic [REM_W+1:0]  r_next;
	logic [REM_W+2:0]  trial;
	logic              ge;
	logic              out_free;
	logic              load_in;
	logic              step;
	logic              load_out;

	assign r_next   = {rem_q, rad_q[SUM_W-1:SUM_W-2]};
	assign trial    = {1'b0, r_next} - (REM_W+3)'({root_q, 2'b01});
	assign ge       = ~trial[REM_W+2];
	assign out_free = ~ovalid_q | m_tready;

	always_comb begin
		state_d  = state_q;
		load_in  = 1'b0;
		step     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					load_in = 1'b1;
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign pop  = load_in;
	assign done = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			rad_q  <= rd_data.sum;
			sat_q  <= rd_data.sat;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= CNT_W'(ROOT_W - 1);
		end else if (step) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= ge ? trial[REM_W-1:0] : r_next[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], ge};
			cnt_q  <= cnt_q - 1'b1;
		end
		if (load_out) begin
			dist_q <= root_q;
			ovf_q  <= sat_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = M_TDATA_W'(dist_q);
	assign m_tuser  = ovf_q;

endmodule

>>> sv/euclidean_vector_distance.sv
// Top level of the Euclidean vector distance block.
//
//  Channel | Direction | Payload                                   | Beat
//  s_*     | in        | tdata: elem_a[15:0], elem_b[31:16]; tlast | one element pair
//  m_*     | out       | tdata: distance[22:0], pad; tuser: overflow | one distance
//
// The accumulator takes one pair per cycle, unless stalled, through front-end stages s1 and s2.
// The bit-serial root unit works on one sum at a time, through its IDLE, CALC and DONE
// states, so it limits throughput for short vectors.
// A two-entry queue holds finished sums; the front end stalls only when a last
// pair meets a full queue. Reset clears the sum, the flag, the queue and the output valid flag.
module euclidean_vector_distance (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [evd_pkg::S_TDATA_W-1:0] s_tdata,  // elem_a, elem_b
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [evd_pkg::M_TDATA_W-1:0] m_tdata,  // distance, zero pad
	output logic                          m_tuser   // overflow
);
	import evd_pkg::*;

	evd_entry_t  wr_entry;
	evd_entry_t  rd_entry;
	evd_q_stat_t q_stat;
	logic        q_push;
	logic        q_pop;
	logic        root_done;

	evd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_stat   (q_stat),
		.push     (q_push),
		.entry    (wr_entry)
	);

	evd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (wr_entry),
		.pop     (q_pop),
		.rd_data (rd_entry),
		.stat    (q_stat)
	);

	evd_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.rd_data  (rd_entry),
		.pop      (q_pop),
		.done     (root_done),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from an empty queue");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(root_done))
		else $error("result raised without a finished root");

endmodule
